### hdl/coapscan_pkg.sv
// Shared types, constants and helpers for the CoAP option scanner.
// Used by the input register, parser and core in this folder; depends on nothing.
package coapscan_pkg;

  localparam int unsigned HEADER_BYTES_DEF = 4;

  localparam int unsigned HDR_CNT_W = 3;
  localparam int unsigned TOKEN_W   = 4;
  localparam int unsigned EXT_W     = 2;
  localparam int unsigned ACC_W     = 17;
  localparam int unsigned OPTNUM_W  = 20;
  localparam int unsigned TARGET_W  = 16;

  localparam logic [TARGET_W-1:0] TARGET_RESET = 16'd9;
  localparam logic [OPTNUM_W-1:0] OPTNUM_MAX   = 20'hFFFFF;

  localparam logic [3:0]       NIB_END   = 4'hF;
  localparam logic [3:0]       NIB_EXT1  = 4'd13;
  localparam logic [3:0]       NIB_EXT2  = 4'd14;
  localparam logic [ACC_W-1:0] ACC_EXT1  = 17'd13;
  localparam logic [ACC_W-1:0] ACC_EXT2  = 17'd14;
  localparam logic [ACC_W-1:0] ACC_BASE2 = 17'd269;   // 14 + 255

  localparam logic [EXT_W-1:0] EXT_ONE = 2'd1;
  localparam logic [EXT_W-1:0] EXT_TWO = 2'd2;

  typedef enum logic [6:0] {
    PH_HEADER = 7'b0000001,
    PH_TOKEN  = 7'b0000010,
    PH_OPT    = 7'b0000100,
    PH_DEXT   = 7'b0001000,
    PH_LEXT   = 7'b0010000,
    PH_SKIP   = 7'b0100000,
    PH_DONE   = 7'b1000000
  } phase_t;

  // One byte leaving the input register towards the parser.
  typedef struct packed {
    logic       fire;
    logic [7:0] data;
    logic       last;
  } step_t;

  // Adds an extension byte: the first of two is the high byte.
  function automatic logic [ACC_W-1:0] ext_add(input logic [ACC_W-1:0] acc,
                                               input logic [7:0]       b,
                                               input logic [EXT_W-1:0] cnt);
    logic [ACC_W-1:0] addend;
    addend = (cnt == EXT_TWO) ? {1'b0, b, 8'h00} : {9'h000, b};
    return acc + addend;
  endfunction

endpackage

### hdl/coapscan_in_reg.sv
// Input register of the CoAP option scanner: holds one message byte.
// Depends on coapscan_pkg for the step_t struct.
module coapscan_in_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] msg_byte
  input  logic                 s_axis_tlast,
  input  logic                 out_free,
  output coapscan_pkg::step_t  step
);
  import coapscan_pkg::*;

  logic       valid;
  logic [7:0] data;
  logic       last;
  logic       advance;

  // A byte that closes a message needs room in the result register.
  assign advance       = valid && (!last || out_free);
  assign s_axis_tready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_axis_tready) begin
      valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      data <= s_axis_tdata;
      last <= s_axis_tlast;
    end
  end

  assign step.fire = advance;
  assign step.data = data;
  assign step.last = last;

endmodule

### hdl/coapscan_parser.sv
// Parse state and next-state logic of the CoAP option scanner.
// Depends on coapscan_pkg for phase codes, widths and ext_add.
module coapscan_parser #(
  parameter int unsigned HEADER_BYTES = coapscan_pkg::HEADER_BYTES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  coapscan_pkg::step_t                  step,
  input  logic [coapscan_pkg::TARGET_W-1:0]    target_option,
  output logic                                 hit_next
);
  import coapscan_pkg::*;

  localparam logic [HDR_CNT_W:0] HdrLimit = (HDR_CNT_W+1)'(HEADER_BYTES);

  phase_t                phase,         phase_next;
  logic [HDR_CNT_W-1:0]  header_count,  header_count_next;
  logic [TOKEN_W-1:0]    token_left,    token_left_next;
  logic [EXT_W-1:0]      ext_count,     ext_count_next;
  logic [ACC_W-1:0]      delta_accum,   delta_accum_next;
  logic [ACC_W-1:0]      length_accum,  length_accum_next;
  logic [OPTNUM_W-1:0]   opt_num,       opt_num_next;
  logic [ACC_W-1:0]      skip_left,     skip_left_next;
  logic                  hit;

  always_comb begin
    logic              do_len;
    logic              do_fin;
    logic [OPTNUM_W:0] sum;
    phase_next         = phase;
    header_count_next  = header_count;
    token_left_next    = token_left;
    ext_count_next     = ext_count;
    delta_accum_next   = delta_accum;
    length_accum_next  = length_accum;
    opt_num_next       = opt_num;
    skip_left_next     = skip_left;
    hit_next           = hit;
    do_len             = 1'b0;
    do_fin             = 1'b0;
    sum                = '0;

    unique case (phase)
      PH_HEADER: begin
        if (header_count == '0) begin
          token_left_next = step.data[3:0];
        end
        header_count_next = header_count + 1'b1;
        if (header_count_next == '0 || {1'b0, header_count_next} >= HdrLimit) begin
          phase_next = (token_left_next != '0) ? PH_TOKEN : PH_OPT;
        end
      end
      PH_TOKEN: begin
        token_left_next = token_left - 1'b1;
        if (token_left_next == '0) begin
          phase_next = PH_OPT;
        end
      end
      PH_OPT: begin
        if (step.data[7:4] == NIB_END) begin
          phase_next = PH_DONE;
        end else begin
          delta_accum_next  = {13'h0000, step.data[7:4]};
          length_accum_next = {13'h0000, step.data[3:0]};
          if (step.data[7:4] == NIB_EXT1) begin
            ext_count_next = EXT_ONE;
            phase_next     = PH_DEXT;
          end else if (step.data[7:4] == NIB_EXT2) begin
            delta_accum_next = ACC_BASE2;
            ext_count_next   = EXT_TWO;
            phase_next       = PH_DEXT;
          end else begin
            do_len = 1'b1;
          end
        end
      end
      PH_DEXT: begin
        delta_accum_next = ext_add(delta_accum, step.data, ext_count);
        ext_count_next   = ext_count - 1'b1;
        if (ext_count_next == '0) begin
          do_len = 1'b1;
        end
      end
      PH_LEXT: begin
        length_accum_next = ext_add(length_accum, step.data, ext_count);
        ext_count_next    = ext_count - 1'b1;
        if (ext_count_next == '0) begin
          do_fin = 1'b1;
        end
      end
      PH_SKIP: begin
        skip_left_next = skip_left - 1'b1;
        if (skip_left_next == '0) begin
          phase_next = PH_OPT;
        end
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase

    if (do_len) begin
      if (length_accum_next == ACC_EXT1) begin
        ext_count_next = EXT_ONE;
        phase_next     = PH_LEXT;
      end else if (length_accum_next == ACC_EXT2) begin
        length_accum_next = ACC_BASE2;
        ext_count_next    = EXT_TWO;
        phase_next        = PH_LEXT;
      end else begin
        do_fin = 1'b1;
      end
    end

    // Close the option: add the delta, saturating, and test for the target.
    if (do_fin) begin
      sum = {1'b0, opt_num} + {4'h0, delta_accum_next};
      opt_num_next = sum[OPTNUM_W] ? OPTNUM_MAX : sum[OPTNUM_W-1:0];
      if (opt_num_next == {4'h0, target_option}) begin
        hit_next   = 1'b1;
        phase_next = PH_DONE;
      end else begin
        skip_left_next = length_accum_next;
        phase_next     = (length_accum_next != '0) ? PH_SKIP : PH_OPT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step.fire && step.last)) begin
      phase         <= PH_HEADER;
      header_count  <= '0;
      token_left    <= '0;
      ext_count     <= '0;
      delta_accum   <= '0;
      length_accum  <= '0;
      opt_num       <= '0;
      skip_left     <= '0;
      hit           <= 1'b0;
    end else if (step.fire) begin
      phase         <= phase_next;
      header_count  <= header_count_next;
      token_left    <= token_left_next;
      ext_count     <= ext_count_next;
      delta_accum   <= delta_accum_next;
      length_accum  <= length_accum_next;
      opt_num       <= opt_num_next;
      skip_left     <= skip_left_next;
      hit           <= hit_next;
    end
  end

endmodule

### hdl/coapscan_out_reg.sv
// Result register of the CoAP option scanner: holds one found flag.
// Depends on nothing beyond its ports.
module coapscan_out_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  logic       found,
  output logic       out_free,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata   // [0] found, [7:1] zero
);

  logic held;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && out_free) begin
      held <= found;
    end
  end

  assign m_axis_tdata = {7'h00, held};

endmodule

### hdl/coap_option_scanner_core.sv
// CoAP option scanner for UDP messages, one message byte per request.
// Input channel (s_axis): tdata[7:0] is the message byte, tlast marks the
// final byte of the message. Output channel (m_axis): one request per
// message, tdata[0] = 1 when the target option number was met before a
// payload marker or the end. Configuration channel (cfg): writes the
// 16-bit target option number, reset value 9; write it only when idle.
// Throughput is one byte per cycle unless a last byte waits for a stalled
// result. A byte passes through an input register and the parse logic into
// the result register, which offers the result request once the last byte
// has left the input register. If the receiver stalls while a result is
// held, bytes keep flowing until the next last byte, which waits in the
// input register; then tready drops. Synchronous reset clears the parse
// state and both registers and sets the target option to its reset value 9.
module coap_option_scanner_core #(
  parameter int unsigned HEADER_BYTES = coapscan_pkg::HEADER_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,   // [7:0] msg_byte
  input  logic                               s_axis_tlast,   // last_byte
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [7:0]                         m_axis_tdata,   // [0] found, [7:1] zero
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [coapscan_pkg::TARGET_W-1:0]  cfg_target_option
);
  import coapscan_pkg::*;

  step_t               step;
  logic                out_free;
  logic                hit_next;
  logic [TARGET_W-1:0] target_option;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_option <= TARGET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      target_option <= cfg_target_option;
    end
  end

  coapscan_in_reg u_in_reg (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .out_free      (out_free),
    .step          (step)
  );

  coapscan_parser #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .target_option (target_option),
    .hit_next      (hit_next)
  );

  coapscan_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .load          (step.fire && step.last),
    .found         (hit_next),
    .out_free      (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

`ifndef ASSERT_OFF
  // Input back-pressure only comes from a stalled result.
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a held result");

  // A new result only follows a byte that closed a message.
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && $past(!m_axis_tvalid || m_axis_tready) && !$past(rst))
      |-> $past(step.fire && step.last))
    else $error("result without a closing byte");

  // A closing byte is never released while the result register is busy.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (step.fire && step.last) |-> out_free)
    else $error("result register overwritten");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for coap_option_scanner_core: drives CoAP messages byte by byte,
// predicts the found flag of each message and checks every result request.
// Depends on coapscan_pkg and the scanner RTL only.
module testbench;
  import coapscan_pkg::*;

  localparam int unsigned HDR_BYTES      = HEADER_BYTES_DEF;
  localparam int unsigned EXT1_MIN       = 13;
  localparam int unsigned EXT2_MIN       = 269;
  localparam int unsigned CODED_MAX      = 65804;   // 269 + 0xFFFF
  localparam logic [7:0]  PAYLOAD_MARKER = 8'hFF;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SEGMENTS       = 6;
  localparam int unsigned ITEMS_PER_SEG  = 234;
  localparam int unsigned DIR_ROWS       = 29;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;   // found below is read straight off the message
    logic       found;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = 8'h00;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [TARGET_W-1:0] cfg_target_option = '0;

  // Scanner state as predicted by the bench.
  phase_t              sc_phase;
  logic [HDR_CNT_W-1:0] sc_hdr_cnt;
  logic [TOKEN_W-1:0]  sc_token_left;
  logic [EXT_W-1:0]    sc_ext_left;
  logic [ACC_W-1:0]    sc_delta;
  logic [ACC_W-1:0]    sc_len;
  logic [OPTNUM_W-1:0] sc_num;
  logic [ACC_W-1:0]    sc_skip;
  logic                sc_hit;
  logic [TARGET_W-1:0] target_q;

  logic                found_q [$];
  logic [1:0]          typed_q [$];
  logic [7:0]          msg_bytes [$];
  logic                want_found;
  logic [1:0]          typed_entry;
  int unsigned         errors = 0;
  int unsigned         quiet_cycles = 0;
  int unsigned         snd_idle_pct = 17;
  int unsigned         rcv_stall_pct = 68;
  int unsigned         hold_left = 0;
  bit                  hold_req = 1'b0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // message ends inside the fixed header
    {8'h00, 1'b1, 1'b1, 1'b0},
    // token of nine bytes, message ends inside it
    {8'h49, 1'b0, 1'b0, 1'b0}, {8'h00, 1'b0, 1'b0, 1'b0}, {8'h00, 1'b0, 1'b0, 1'b0},
    {8'h00, 1'b0, 1'b0, 1'b0}, {8'hFF, 1'b1, 1'b1, 1'b0},
    // one-byte delta extension, plain length 15, value runs past the end
    {8'h40, 1'b0, 1'b0, 1'b0}, {8'h00, 1'b0, 1'b0, 1'b0}, {8'h00, 1'b0, 1'b0, 1'b0},
    {8'h00, 1'b0, 1'b0, 1'b0}, {8'hDF, 1'b0, 1'b0, 1'b0}, {8'hFF, 1'b0, 1'b0, 1'b0},
    {8'h00, 1'b1, 1'b0, 1'b0},
    // option 9 met once its one-byte length extension is in
    {8'h40, 1'b0, 1'b0, 1'b0}, {8'h00, 1'b0, 1'b0, 1'b0}, {8'h00, 1'b0, 1'b0, 1'b0},
    {8'h00, 1'b0, 1'b0, 1'b0}, {8'h9D, 1'b0, 1'b0, 1'b0}, {8'h05, 1'b1, 1'b0, 1'b0},
    // two-byte delta, one value byte, then an end marker and an ignored byte
    {8'h40, 1'b0, 1'b0, 1'b0}, {8'h00, 1'b0, 1'b0, 1'b0}, {8'h00, 1'b0, 1'b0, 1'b0},
    {8'h00, 1'b0, 1'b0, 1'b0}, {8'hE1, 1'b0, 1'b0, 1'b0}, {8'h00, 1'b0, 1'b0, 1'b0},
    {8'h00, 1'b0, 1'b0, 1'b0}, {8'hAB, 1'b0, 1'b0, 1'b0}, {8'hF0, 1'b0, 1'b0, 1'b0},
    {8'h11, 1'b1, 1'b0, 1'b0}
  };

  coap_option_scanner_core #(.HEADER_BYTES(HDR_BYTES)) dut (
    .clk               (clk),
    .rst               (rst),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),   // [7:0] msg_byte
    .s_axis_tlast      (s_axis_tlast),   // last_byte
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata),   // [0] found, [7:1] zero
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_target_option (cfg_target_option)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void clear_scan();
    sc_phase      = PH_HEADER;
    sc_hdr_cnt    = '0;
    sc_token_left = '0;
    sc_ext_left   = '0;
    sc_delta      = '0;
    sc_len        = '0;
    sc_num        = '0;
    sc_skip       = '0;
    sc_hit        = 1'b0;
  endfunction

  // Adds the delta to the option number and either records a hit or sets up the value skip.
  function automatic void close_option();
    logic [OPTNUM_W:0] sum;
    sum = {1'b0, sc_num} + (OPTNUM_W+1)'(sc_delta);
    sc_num = sum[OPTNUM_W] ? OPTNUM_MAX : sum[OPTNUM_W-1:0];
    if (sc_num == OPTNUM_W'(target_q)) begin
      sc_hit   = 1'b1;
      sc_phase = PH_DONE;
    end else begin
      sc_skip = sc_len;
      if (sc_len != 0) sc_phase = PH_SKIP;
      else sc_phase = PH_OPT;
    end
  endfunction

  function automatic void open_length();
    if (sc_len == ACC_EXT1) begin
      sc_ext_left = EXT_ONE;
      sc_phase    = PH_LEXT;
    end else if (sc_len == ACC_EXT2) begin
      sc_len      = ACC_BASE2;
      sc_ext_left = EXT_TWO;
      sc_phase    = PH_LEXT;
    end else begin
      close_option();
    end
  endfunction

  function automatic void scan_byte(input logic [7:0] b);
    case (sc_phase)
      PH_HEADER: begin
        if (sc_hdr_cnt == 0) sc_token_left = b[3:0];
        sc_hdr_cnt = sc_hdr_cnt + 1'b1;
        if (sc_hdr_cnt == 0 || sc_hdr_cnt >= HDR_BYTES) begin
          if (sc_token_left != 0) sc_phase = PH_TOKEN;
          else sc_phase = PH_OPT;
        end
      end
      PH_TOKEN: begin
        sc_token_left = sc_token_left - 1'b1;
        if (sc_token_left == 0) sc_phase = PH_OPT;
      end
      PH_OPT: begin
        if (b[7:4] == NIB_END) begin
          sc_phase = PH_DONE;
        end else begin
          sc_delta = ACC_W'(b[7:4]);
          sc_len   = ACC_W'(b[3:0]);
          if (b[7:4] == NIB_EXT1) begin
            sc_ext_left = EXT_ONE;
            sc_phase    = PH_DEXT;
          end else if (b[7:4] == NIB_EXT2) begin
            sc_delta    = ACC_BASE2;
            sc_ext_left = EXT_TWO;
            sc_phase    = PH_DEXT;
          end else begin
            open_length();
          end
        end
      end
      PH_DEXT: begin
        // With two extension bytes the first one is the high byte.
        sc_delta = sc_delta + ((sc_ext_left == EXT_TWO) ? {1'b0, b, 8'h00} : ACC_W'(b));
        sc_ext_left = sc_ext_left - 1'b1;
        if (sc_ext_left == 0) open_length();
      end
      PH_LEXT: begin
        sc_len = sc_len + ((sc_ext_left == EXT_TWO) ? {1'b0, b, 8'h00} : ACC_W'(b));
        sc_ext_left = sc_ext_left - 1'b1;
        if (sc_ext_left == 0) close_option();
      end
      PH_SKIP: begin
        sc_skip = sc_skip - 1'b1;
        if (sc_skip == 0) sc_phase = PH_OPT;
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      target_q = TARGET_RESET;
      clear_scan();
    end else begin
      if (cfg_valid && cfg_ready) target_q = cfg_target_option;
      if (m_axis_tvalid && m_axis_tready) begin
        if (found_q.size() == 0) begin
          $display("%0t: result request with nothing expected, tdata=%h", $time,
                   m_axis_tdata);
          errors++;
        end else begin
          want_found = found_q.pop_front();
          if (m_axis_tdata[0] !== want_found) begin
            $display("%0t: found mismatch, expected %b, actual %b", $time, want_found,
                     m_axis_tdata[0]);
            errors++;
          end
          if (m_axis_tdata[7:1] !== 7'd0) begin
            $display("%0t: tdata padding mismatch, expected 00, actual %h", $time,
                     m_axis_tdata[7:1]);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        scan_byte(s_axis_tdata);
        if (s_axis_tlast) begin
          want_found = sc_hit;
          if (typed_q.size() != 0) begin
            typed_entry = typed_q.pop_front();
            if (typed_entry[1]) want_found = typed_entry[0];
          end
          found_q.push_back(want_found);
          clear_scan();
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off when asked for.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic write_target(input logic [TARGET_W-1:0] value);
    cfg_target_option <= value;
    cfg_valid         <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (found_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [3:0] nibble_for(input int unsigned v, input bit plain15);
    if (v < EXT1_MIN || (plain15 && v == 15)) return 4'(v);
    return (v < EXT2_MIN) ? NIB_EXT1 : NIB_EXT2;
  endfunction

  function automatic void push_ext(input int unsigned v);
    if (v >= EXT2_MIN) begin
      msg_bytes.push_back(8'((v - EXT2_MIN) >> 8));
      msg_bytes.push_back(8'(v - EXT2_MIN));
    end else if (v >= EXT1_MIN) begin
      msg_bytes.push_back(8'(v - EXT1_MIN));
    end
  endfunction

  // Builds one message: mostly well-formed option lists that often land on the target
  // number, a few that drive the option number into saturation, and some pure noise.
  function automatic void compose_message();
    int unsigned kind, tkl, num, d, ln, pick;
    msg_bytes.delete();
    kind = $urandom_range(99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 12)) msg_bytes.push_back(8'($urandom_range(255)));
      return;
    end
    tkl = ($urandom_range(9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
    msg_bytes.push_back({4'($urandom_range(15)), 4'(tkl)});
    repeat (HDR_BYTES - 1) msg_bytes.push_back(8'($urandom_range(255)));
    repeat (tkl) msg_bytes.push_back(8'($urandom_range(255)));
    if (kind < 16) begin
      repeat ($urandom_range(16, 18)) begin
        msg_bytes.push_back({NIB_EXT2, 4'd0});
        msg_bytes.push_back(8'hFF);
        msg_bytes.push_back(8'hFF);
      end
      msg_bytes.push_back(8'h00);
    end else begin
      num = 0;
      repeat ($urandom_range(0, 6)) begin
        if (num <= target_q && target_q - num <= CODED_MAX && $urandom_range(2) == 0) begin
          d = target_q - num;
        end else begin
          pick = $urandom_range(9);
          if (pick < 6) d = $urandom_range(0, 12);
          else if (pick < 9) d = $urandom_range(EXT1_MIN, EXT2_MIN - 1);
          else d = $urandom_range(EXT2_MIN, CODED_MAX);
        end
        num += d;
        pick = $urandom_range(99);
        if (pick < 55) ln = $urandom_range(0, 12);
        else if (pick < 65) ln = 15;
        else if (pick < 85) ln = $urandom_range(EXT1_MIN, 40);
        else if (pick < 90) ln = $urandom_range(EXT1_MIN, EXT2_MIN - 1);
        else if (pick < 93) ln = $urandom_range(EXT2_MIN, EXT2_MIN + 20);
        else ln = 0;
        msg_bytes.push_back({nibble_for(d, 1'b0), nibble_for(ln, 1'b1)});
        push_ext(d);
        if (ln != 15) push_ext(ln);
        repeat (ln) msg_bytes.push_back(8'($urandom_range(255)));
      end
      pick = $urandom_range(9);
      if (pick < 4) begin
        msg_bytes.push_back(PAYLOAD_MARKER);
        repeat ($urandom_range(0, 4)) msg_bytes.push_back(8'($urandom_range(255)));
      end else if (pick == 4) begin
        msg_bytes.push_back({NIB_END, 4'($urandom_range(15))});
      end
    end
    // Cut some messages short so that they end mid-header, mid-token or mid-option.
    if ($urandom_range(4) == 0) begin
      pick = $urandom_range(1, msg_bytes.size());
      while (msg_bytes.size() > pick) void'(msg_bytes.pop_back());
    end
  endfunction

  initial begin
    int unsigned seg_items;
    logic [TARGET_W-1:0] seg_target [SEGMENTS];
    seg_target = '{16'd0, 16'hFFFF, 16'd269, 16'd13, 16'($urandom_range(1, 600)), 16'd9};
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].last) typed_q.push_back({dir_rows[i].typed, dir_rows[i].found});
      send_byte(dir_rows[i].data, dir_rows[i].last);
    end
    drain_results();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 2)
        0: begin
          snd_idle_pct  = 17;
          rcv_stall_pct = 68;
        end
        1: begin
          snd_idle_pct  = 68;
          rcv_stall_pct = 17;
        end
        default: begin
          snd_idle_pct  = 0;
          rcv_stall_pct = 0;
        end
      endcase
      write_target(seg_target[seg]);
      // The sender keeps offering requests while the receiver is held off, so the
      // scanner fills up and pushes back on its input.
      if (seg == 0) hold_req = 1'b1;
      seg_items = 0;
      while (seg_items < ITEMS_PER_SEG) begin
        compose_message();
        foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
        seg_items += msg_bytes.size();
      end
      drain_results();
    end

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
